### rtl/core/cddn_pkg.sv
// ----------------------------------------------------------------------------
// cddn_pkg
// Shared types, constants and calendar helpers for the date / day number
// converter.
// ----------------------------------------------------------------------------
package cddn_pkg;

   localparam int YEAR_SPAN_DEF = 256;
   localparam int BASE_YEAR     = 1900;
   localparam int BASE_MOD400   = 300;

   localparam int YEAR_W = 12;
   localparam int MON_W  = 4;
   localparam int DAY_W  = 5;
   localparam int DN_W   = 17;
   localparam int ST_W   = 3;

   localparam logic [ST_W-1:0] ST_OK       = 3'd0;
   localparam logic [ST_W-1:0] ST_EARLY    = 3'd1;
   localparam logic [ST_W-1:0] ST_BAD_MON  = 3'd2;
   localparam logic [ST_W-1:0] ST_BAD_DAY  = 3'd3;
   localparam logic [ST_W-1:0] ST_SPAN     = 3'd4;

   localparam logic FUNC_TO_DN   = 1'b0;
   localparam logic FUNC_TO_DATE = 1'b1;

   localparam logic [DAY_W-1:0] MONTH_LEN [12] = '{
      5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
      5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
   };

   typedef enum logic [1:0] {
      S_IDLE,
      S_YEAR,
      S_MONTH,
      S_FIN
   } state_type;

   typedef struct packed {
      logic load;
      logic year_step;
      logic year_end;
      logic month_step;
      logic finish;
   } dp_cmd_type;

   typedef struct packed {
      logic err;
      logic year_stop;
      logic month_stop;
   } dp_stat_type;

   function automatic logic [DAY_W-1:0] mon_len(input logic leap, input logic [MON_W-1:0] m0);
      logic [DAY_W-1:0] n;
      n = 5'd31;
      if (m0 < 4'd12) begin
         n = MONTH_LEN[m0];
      end
      if (m0 == 4'd1 && leap) begin
         n = 5'd29;
      end
      return n;
   endfunction

   function automatic logic [8:0] year_len(input logic leap);
      return leap ? 9'd366 : 9'd365;
   endfunction

endpackage

### rtl/core/cddn_ctrl.sv
// ----------------------------------------------------------------------------
// cddn_ctrl
// Sequencer: accepts a beat, steps the datapath through years and months,
// then hands the result to the output register.
// ----------------------------------------------------------------------------
module cddn_ctrl import cddn_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   input  dp_stat_type stat,
   output dp_cmd_type  cmd
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      slot_free;

   assign slot_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in = S_YEAR;
            end
         end
         S_YEAR: begin
            if (stat.err) begin
               state_in = S_FIN;
            end else if (stat.year_stop) begin
               state_in = S_MONTH;
            end
         end
         S_MONTH: begin
            if (stat.err || stat.month_stop) begin
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            if (slot_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         S_IDLE: begin
            req_stall = 1'b0;
            cmd.load  = req_valid;
         end
         S_YEAR: begin
            if (!stat.err) begin
               cmd.year_end  = stat.year_stop;
               cmd.year_step = !stat.year_stop;
            end
         end
         S_MONTH: begin
            cmd.month_step = !stat.err && !stat.month_stop;
         end
         S_FIN: begin
            cmd.finish = slot_free;
         end
         default: ;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

### rtl/core/cddn_dp.sv
// ----------------------------------------------------------------------------
// cddn_dp
// Datapath: range checks, year and month walk with a running total or
// remainder, leap tracking by mod-100 / mod-400 counters, result register.
// ----------------------------------------------------------------------------
module cddn_dp import cddn_pkg::*; #(
   parameter int YEAR_SPAN = YEAR_SPAN_DEF
) (
   input  logic              clock,
   input  dp_cmd_type        cmd,
   output dp_stat_type       stat,
   input  logic              req_func,
   input  logic [YEAR_W-1:0] req_in_year,
   input  logic [MON_W-1:0]  req_in_month,
   input  logic [DAY_W-1:0]  req_in_day,
   input  logic [DN_W-1:0]   req_in_day_number,
   output logic [DN_W-1:0]   rsp_out_day_number,
   output logic [YEAR_W-1:0] rsp_out_year,
   output logic [MON_W-1:0]  rsp_out_month,
   output logic [DAY_W-1:0]  rsp_out_day,
   output logic [ST_W-1:0]   rsp_status
);

   localparam int SUM_MAX = YEAR_SPAN * 366 + 400;
   localparam int SUM_W   = $clog2(SUM_MAX + 1);
   localparam int ACC_W   = (SUM_W > DN_W) ? SUM_W : DN_W;
   localparam logic [YEAR_W-1:0] YEAR_LIMIT = YEAR_W'(BASE_YEAR + YEAR_SPAN);
   localparam logic [YEAR_W-1:0] YEAR_BASE  = YEAR_W'(BASE_YEAR);
   localparam logic [ACC_W:0]    DN_MAX     = (ACC_W+1)'(2**DN_W - 1);

   logic              func_ff;
   logic [YEAR_W-1:0] ytgt_ff;
   logic [MON_W-1:0]  mtgt_ff;
   logic [DAY_W-1:0]  dtgt_ff;
   logic [ACC_W-1:0]  rem_ff, rem_in;
   logic [YEAR_W-1:0] yr_ff, yr_in;
   logic [6:0]        c100_ff, c100_in;
   logic [8:0]        c400_ff, c400_in;
   logic [MON_W-1:0]  mon_ff, mon_in;
   logic [ST_W-1:0]   st_ff, st_in;

   logic [DN_W-1:0]   odn_ff, odn_in;
   logic [YEAR_W-1:0] oyr_ff, oyr_in;
   logic [MON_W-1:0]  omon_ff, omon_in;
   logic [DAY_W-1:0]  oday_ff, oday_in;
   logic [ST_W-1:0]   ost_ff, ost_in;

   logic             leap;
   logic [8:0]       ylen;
   logic [DAY_W-1:0] mlen;
   logic [DAY_W-1:0] tlen;
   logic [MON_W-1:0] mlast;
   logic [ACC_W:0]   total;

   assign leap  = (yr_ff[1:0] == 2'd0) && ((c100_ff != 7'd0) || (c400_ff == 9'd0));
   assign ylen  = year_len(leap);
   assign mlen  = mon_len(leap, mon_ff);
   assign mlast = mtgt_ff - 4'd1;
   assign tlen  = mon_len(leap, mlast);
   assign total = {1'b0, rem_ff} + (ACC_W+1)'(dtgt_ff);

   always_comb begin
      stat.err = (st_ff != ST_OK);
      if (func_ff == FUNC_TO_DN) begin
         stat.year_stop  = (yr_ff == ytgt_ff);
         stat.month_stop = (mon_ff == mlast);
      end else begin
         stat.year_stop  = (yr_ff == YEAR_LIMIT) || (rem_ff <= ACC_W'(ylen));
         stat.month_stop = (mon_ff == 4'd11) || (rem_ff <= ACC_W'(mlen));
      end
   end

   always_comb begin
      rem_in  = rem_ff;
      yr_in   = yr_ff;
      c100_in = c100_ff;
      c400_in = c400_ff;
      mon_in  = mon_ff;
      st_in   = st_ff;
      if (cmd.load) begin
         yr_in   = YEAR_BASE;
         c100_in = 7'd0;
         c400_in = 9'(BASE_MOD400);
         mon_in  = '0;
         if (req_func == FUNC_TO_DN) begin
            rem_in = '0;
            if (req_in_year < YEAR_BASE) begin
               st_in = ST_EARLY;
            end else if (req_in_year >= YEAR_LIMIT) begin
               st_in = ST_SPAN;
            end else if (req_in_month < 4'd1 || req_in_month > 4'd12) begin
               st_in = ST_BAD_MON;
            end else begin
               st_in = ST_OK;
            end
         end else begin
            rem_in = ACC_W'(req_in_day_number);
            st_in  = (req_in_day_number == '0) ? ST_SPAN : ST_OK;
         end
      end else if (cmd.year_step) begin
         if (func_ff == FUNC_TO_DN) begin
            rem_in = rem_ff + ACC_W'(ylen);
         end else begin
            rem_in = rem_ff - ACC_W'(ylen);
         end
         yr_in   = yr_ff + 12'd1;
         c100_in = (c100_ff == 7'd99) ? 7'd0 : c100_ff + 7'd1;
         c400_in = (c400_ff == 9'd399) ? 9'd0 : c400_ff + 9'd1;
      end else if (cmd.year_end) begin
         if (func_ff == FUNC_TO_DN) begin
            if (dtgt_ff == '0 || dtgt_ff > tlen) begin
               st_in = ST_BAD_DAY;
            end
         end else if (yr_ff == YEAR_LIMIT) begin
            st_in = ST_SPAN;
         end
      end else if (cmd.month_step) begin
         if (func_ff == FUNC_TO_DN) begin
            rem_in = rem_ff + ACC_W'(mlen);
         end else begin
            rem_in = rem_ff - ACC_W'(mlen);
         end
         mon_in = mon_ff + 4'd1;
      end
   end

   always_comb begin
      odn_in  = odn_ff;
      oyr_in  = oyr_ff;
      omon_in = omon_ff;
      oday_in = oday_ff;
      ost_in  = ost_ff;
      if (cmd.finish) begin
         odn_in  = '0;
         oyr_in  = '0;
         omon_in = '0;
         oday_in = '0;
         ost_in  = st_ff;
         if (st_ff == ST_OK) begin
            if (func_ff == FUNC_TO_DN) begin
               if (total > DN_MAX) begin
                  ost_in = ST_SPAN;
               end else begin
                  odn_in = total[DN_W-1:0];
               end
            end else begin
               oyr_in  = yr_ff;
               omon_in = mon_ff + 4'd1;
               oday_in = rem_ff[DAY_W-1:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         func_ff <= req_func;
         ytgt_ff <= req_in_year;
         mtgt_ff <= req_in_month;
         dtgt_ff <= req_in_day;
      end
      rem_ff  <= rem_in;
      yr_ff   <= yr_in;
      c100_ff <= c100_in;
      c400_ff <= c400_in;
      mon_ff  <= mon_in;
      st_ff   <= st_in;
      odn_ff  <= odn_in;
      oyr_ff  <= oyr_in;
      omon_ff <= omon_in;
      oday_ff <= oday_in;
      ost_ff  <= ost_in;
   end

   assign rsp_out_day_number = odn_ff;
   assign rsp_out_year       = oyr_ff;
   assign rsp_out_month      = omon_ff;
   assign rsp_out_day        = oday_ff;
   assign rsp_status         = ost_ff;

endmodule

### rtl/core/calendar_date_day_number_converter.sv
// ----------------------------------------------------------------------------
// calendar_date_day_number_converter
// Gregorian date <-> serial day number (1 Jan 1900 = day 1), with range
// and validity checks over YEAR_SPAN years.
//
//   channel  ports                                         dir
//   req      req_valid/req_stall, req_func, req_in_*       in
//   rsp      rsp_valid/rsp_stall, rsp_out_*, rsp_status    out
//
// One beat at a time: the beat is accepted, the datapath walks the years
// and then the months, and the result register is loaded; a bad year, month
// or zero day number skips the walk. The load waits while a stalled result
// holds the output register; no new beat is taken until the load is done.
// Synchronous active-high reset clears the sequencer and rsp_valid.
// ----------------------------------------------------------------------------
module calendar_date_day_number_converter import cddn_pkg::*; #(
   parameter int YEAR_SPAN = YEAR_SPAN_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic              req_func,
   input  logic [YEAR_W-1:0] req_in_year,
   input  logic [MON_W-1:0]  req_in_month,
   input  logic [DAY_W-1:0]  req_in_day,
   input  logic [DN_W-1:0]   req_in_day_number,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [DN_W-1:0]   rsp_out_day_number,
   output logic [YEAR_W-1:0] rsp_out_year,
   output logic [MON_W-1:0]  rsp_out_month,
   output logic [DAY_W-1:0]  rsp_out_day,
   output logic [ST_W-1:0]   rsp_status
);

   dp_cmd_type  cmd;
   dp_stat_type stat;

   cddn_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   cddn_dp #(
      .YEAR_SPAN (YEAR_SPAN)
   ) u_dp (
      .clock              (clock),
      .cmd                (cmd),
      .stat               (stat),
      .req_func           (req_func),
      .req_in_year        (req_in_year),
      .req_in_month       (req_in_month),
      .req_in_day         (req_in_day),
      .req_in_day_number  (req_in_day_number),
      .rsp_out_day_number (rsp_out_day_number),
      .rsp_out_year       (rsp_out_year),
      .rsp_out_month      (rsp_out_month),
      .rsp_out_day        (rsp_out_day),
      .rsp_status         (rsp_status)
   );

endmodule
